>>> rtl/dwpd_pkg.sv
// ----------------------------------------------------------------------------
// dwpd_pkg
// Shared widths, register map, direction codes and inter-stage bundles of the
// dual-wheel PD position controller.
// ----------------------------------------------------------------------------
package dwpd_pkg;

   localparam int ENC_W    = 20;
   localparam int POS_W    = 28;
   localparam int ERR_W    = 29;
   localparam int DERR_W   = 30;
   localparam int GAIN_W   = 16;
   localparam int PWM_W    = 12;
   localparam int OUT_W    = 14;
   localparam int CNT_W    = 8;
   localparam int FRAC_W   = 12;
   localparam int DIR_W    = 2;

   localparam int PROP_W   = ERR_W + GAIN_W + 1;
   localparam int DPROD_W  = DERR_W + GAIN_W + 1;
   localparam int SUM_W    = DPROD_W + 1;
   localparam int SYNC_W   = ERR_W + GAIN_W + 1;
   localparam int PD_W     = PWM_W + FRAC_W + 1;
   localparam int OSUM_W   = SYNC_W + 1;
   localparam int Q_W      = OSUM_W - FRAC_W;

   localparam int OUT_LIMIT = 8191;

   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int REG_IDX_W = 3;

   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_GOAL_LEFT   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GOAL_RIGHT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KP_LINE     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KD_LINE     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_KP_TURN     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_KD_TURN     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_KP_SYNC     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_PWM_MAX     = 3'd7;

   typedef struct packed {
      logic signed [POS_W-1:0] goal_left;
      logic signed [POS_W-1:0] goal_right;
      logic [GAIN_W-1:0]       kp_line;
      logic [GAIN_W-1:0]       kd_line;
      logic [GAIN_W-1:0]       kp_turn;
      logic [GAIN_W-1:0]       kd_turn;
      logic [GAIN_W-1:0]       kp_sync;
      logic [PWM_W-1:0]        pwm_max;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic                     turning;
      logic                     done;
      logic signed [ERR_W-1:0]  err_l;
      logic signed [ERR_W-1:0]  err_r;
      logic signed [DERR_W-1:0] derr_l;
      logic signed [DERR_W-1:0] derr_r;
      logic signed [ERR_W-1:0]  sync_e;
   } trk_type;

   typedef struct packed {
      logic                     valid;
      logic                     turning;
      logic                     done;
      logic signed [PD_W-1:0]   pd_l;
      logic signed [PD_W-1:0]   pd_r;
      logic signed [SYNC_W-1:0] sync;
   } pd_type;

endpackage

>>> rtl/dwpd_if.sv
// ----------------------------------------------------------------------------
// dwpd_req_if / dwpd_rsp_if
// Valid/ready channels carrying one control tick and one drive result.
// ----------------------------------------------------------------------------
interface dwpd_req_if;
   import dwpd_pkg::*;

   logic             valid;
   logic             ready;
   logic [ENC_W-1:0] enc_left_abs;
   logic [ENC_W-1:0] enc_right_abs;
   logic [DIR_W-1:0] dir_left;
   logic [DIR_W-1:0] dir_right;
   logic             turning;
   logic             restart;

   modport source (
      output valid, enc_left_abs, enc_right_abs, dir_left, dir_right, turning, restart,
      input  ready
   );
   modport sink (
      input  valid, enc_left_abs, enc_right_abs, dir_left, dir_right, turning, restart,
      output ready
   );
endinterface

interface dwpd_rsp_if;
   import dwpd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] pwm_left;
   logic signed [OUT_W-1:0] pwm_right;
   logic                    done_res;

   modport source (
      output valid, pwm_left, pwm_right, done_res,
      input  ready
   );
   modport sink (
      input  valid, pwm_left, pwm_right, done_res,
      output ready
   );
endinterface

>>> rtl/dual_wheel_pd_position_control.sv
// ----------------------------------------------------------------------------
// dual_wheel_pd_position_control
// A request beat passes the input, tracker, gain product, PD and result registers.
// Throughput: one tick per cycle unless a stalled result beat holds the pipeline.
// A stalled result beat holds the whole pipeline; ready tracks the output reg.
// Reset (synchronous): empties the pipeline, clears positions, errors, encoder
// history and settle count, and returns all CSR registers to their defaults.
// ----------------------------------------------------------------------------
module dual_wheel_pd_position_control #(
   parameter int SETTLE_TICKS = 20,
   parameter int SETTLE_TOL   = 80
) (
   input  logic                         clock,
   input  logic                         reset,
   dwpd_req_if.sink                     req_bus,
   dwpd_rsp_if.source                   rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dwpd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dwpd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dwpd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import dwpd_pkg::*;

   localparam logic signed [ERR_W-1:0] TOL     = ERR_W'(SETTLE_TOL);
   localparam logic signed [OUT_W-1:0] OUT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   cfg_type cfg;
   trk_type trk;
   pd_type  pd;
   logic    adv;
   logic signed [PD_W-1:0] lim_chk;

   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign lim_chk       = $signed({1'b0, cfg.pwm_max, FRAC_W'(0)});

   dwpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dwpd_track #(
      .SETTLE_TICKS (SETTLE_TICKS),
      .SETTLE_TOL   (SETTLE_TOL)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .cfg     (cfg),
      .req_bus (req_bus),
      .trk     (trk)
   );

   dwpd_gain u_gain (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .cfg   (cfg),
      .trk   (trk),
      .pd    (pd)
   );

   dwpd_out u_out (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .pd      (pd),
      .rsp_bus (rsp_bus)
   );

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result beat valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(trk))
      else $error("tracker stage moved during stall");

   a_pd_clamp: assert property (@(posedge clock) disable iff (reset)
      pd.valid |-> (pd.pd_l <= lim_chk) && (pd.pd_l >= -lim_chk) &&
                   (pd.pd_r <= lim_chk) && (pd.pd_r >= -lim_chk))
      else $error("PD term outside pwm_max clamp");

   a_done_tol: assert property (@(posedge clock) disable iff (reset)
      trk.valid && trk.done |-> (trk.err_l <= TOL) && (trk.err_l >= -TOL) &&
                               (trk.err_r <= TOL) && (trk.err_r >= -TOL))
      else $error("settle flag with error outside tolerance");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.pwm_left != OUT_NEG) && (rsp_bus.pwm_right != OUT_NEG))
      else $error("drive value outside saturation range");

endmodule

>>> rtl/dwpd_csr.sv
// ----------------------------------------------------------------------------
// dwpd_csr
// APB register file holding goals, gains and the PWM clamp.
// ----------------------------------------------------------------------------
module dwpd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dwpd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dwpd_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dwpd_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output dwpd_pkg::cfg_type            cfg
);
   import dwpd_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr;

   assign idx        = csr_paddr[ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_GOAL_LEFT:   cfg_in.goal_left   = csr_pwdata[POS_W-1:0];
            REG_GOAL_RIGHT:  cfg_in.goal_right  = csr_pwdata[POS_W-1:0];
            REG_KP_LINE:     cfg_in.kp_line     = csr_pwdata[GAIN_W-1:0];
            REG_KD_LINE:     cfg_in.kd_line     = csr_pwdata[GAIN_W-1:0];
            REG_KP_TURN:     cfg_in.kp_turn     = csr_pwdata[GAIN_W-1:0];
            REG_KD_TURN:     cfg_in.kd_turn     = csr_pwdata[GAIN_W-1:0];
            REG_KP_SYNC:     cfg_in.kp_sync     = csr_pwdata[GAIN_W-1:0];
            REG_PWM_MAX:     cfg_in.pwm_max     = csr_pwdata[PWM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GOAL_LEFT:   csr_prdata = DATA_W'(cfg_ff.goal_left);
         REG_GOAL_RIGHT:  csr_prdata = DATA_W'(cfg_ff.goal_right);
         REG_KP_LINE:     csr_prdata = DATA_W'(cfg_ff.kp_line);
         REG_KD_LINE:     csr_prdata = DATA_W'(cfg_ff.kd_line);
         REG_KP_TURN:     csr_prdata = DATA_W'(cfg_ff.kp_turn);
         REG_KD_TURN:     csr_prdata = DATA_W'(cfg_ff.kd_turn);
         REG_KP_SYNC:     csr_prdata = DATA_W'(cfg_ff.kp_sync);
         REG_PWM_MAX:     csr_prdata = DATA_W'(cfg_ff.pwm_max);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_left   <= '0;
         cfg_ff.goal_right  <= '0;
         cfg_ff.kp_line     <= GAIN_W'(256);
         cfg_ff.kd_line     <= '0;
         cfg_ff.kp_turn     <= GAIN_W'(256);
         cfg_ff.kd_turn     <= '0;
         cfg_ff.kp_sync     <= '0;
         cfg_ff.pwm_max     <= PWM_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/dwpd_track.sv
// ----------------------------------------------------------------------------
// dwpd_track
// Input register and wheel position tracker: encoder deltas, positions,
// errors, error derivatives, sync error and the settle counter.
// ----------------------------------------------------------------------------
module dwpd_track #(
   parameter int SETTLE_TICKS = 20,
   parameter int SETTLE_TOL   = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  dwpd_pkg::cfg_type   cfg,
   dwpd_req_if.sink            req_bus,
   output dwpd_pkg::trk_type   trk
);
   import dwpd_pkg::*;

   localparam logic signed [ERR_W-1:0] TOL   = ERR_W'(SETTLE_TOL);
   localparam logic [CNT_W-1:0]        TICKS = CNT_W'(SETTLE_TICKS);

   // input beat register
   logic             s0_valid_ff;
   logic [ENC_W-1:0] s0_enc_l_ff, s0_enc_r_ff;
   logic [DIR_W-1:0] s0_dir_l_ff, s0_dir_r_ff;
   logic             s0_turn_ff, s0_rst_ff;

   // tracker state
   logic signed [POS_W-1:0] pos_l_ff, pos_r_ff, pos_l_in, pos_r_in;
   logic [ENC_W-1:0]        prev_enc_l_ff, prev_enc_r_ff, prev_enc_l_in, prev_enc_r_in;
   logic signed [ERR_W-1:0] prev_err_l_ff, prev_err_r_ff, prev_err_l_in, prev_err_r_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   trk_type trk_ff, trk_in;

   logic signed [ENC_W:0]   dl, dr;
   logic signed [POS_W-1:0] np_l, np_r;
   logic signed [ERR_W-1:0] e_l, e_r, px_l, px_r, ab_l, ab_r;
   logic [CNT_W-1:0]        cnt_step;
   logic                    stable;

   function automatic logic signed [POS_W-1:0] step_pos(
      input logic signed [POS_W-1:0] pos,
      input logic signed [ENC_W:0]   delta,
      input logic [DIR_W-1:0]        dir
   );
      logic signed [POS_W:0] s;
      case (dir)
         DIR_FWD:  s = (POS_W+1)'(pos) + (POS_W+1)'(delta);
         DIR_BACK: s = (POS_W+1)'(pos) - (POS_W+1)'(delta);
         default:  s = (POS_W+1)'(pos);
      endcase
      if (s[POS_W] != s[POS_W-1]) begin
         step_pos = {s[POS_W], {(POS_W-1){~s[POS_W]}}};
      end else begin
         step_pos = s[POS_W-1:0];
      end
   endfunction

   assign trk = trk_ff;

   always_comb begin
      dl   = $signed({1'b0, s0_enc_l_ff}) - $signed({1'b0, prev_enc_l_ff});
      dr   = $signed({1'b0, s0_enc_r_ff}) - $signed({1'b0, prev_enc_r_ff});
      np_l = step_pos(pos_l_ff, dl, s0_dir_l_ff);
      np_r = step_pos(pos_r_ff, dr, s0_dir_r_ff);
      e_l  = ERR_W'(cfg.goal_left) - ERR_W'(np_l);
      e_r  = ERR_W'(cfg.goal_right) - ERR_W'(np_r);
      px_l = ERR_W'(np_l);
      px_r = ERR_W'(np_r);
      ab_l = px_l[ERR_W-1] ? -px_l : px_l;
      ab_r = px_r[ERR_W-1] ? -px_r : px_r;

      stable   = (e_l <= TOL) && (e_l >= -TOL) && (e_r <= TOL) && (e_r >= -TOL);
      cnt_step = (&count_ff) ? count_ff : count_ff + CNT_W'(1);

      pos_l_in      = pos_l_ff;
      pos_r_in      = pos_r_ff;
      prev_enc_l_in = prev_enc_l_ff;
      prev_enc_r_in = prev_enc_r_ff;
      prev_err_l_in = prev_err_l_ff;
      prev_err_r_in = prev_err_r_ff;
      count_in      = count_ff;

      trk_in         = trk_ff;
      trk_in.valid   = s0_valid_ff;
      trk_in.turning = s0_turn_ff;

      if (s0_rst_ff) begin
         trk_in.done   = 1'b0;
         trk_in.err_l  = '0;
         trk_in.err_r  = '0;
         trk_in.derr_l = '0;
         trk_in.derr_r = '0;
         trk_in.sync_e = '0;
      end else begin
         trk_in.done   = (stable ? cnt_step : '0) >= TICKS;
         trk_in.err_l  = e_l;
         trk_in.err_r  = e_r;
         trk_in.derr_l = DERR_W'(e_l) - DERR_W'(prev_err_l_ff);
         trk_in.derr_r = DERR_W'(e_r) - DERR_W'(prev_err_r_ff);
         trk_in.sync_e = s0_turn_ff ? (ab_r - ab_l) : (px_r - px_l);
      end

      if (s0_valid_ff) begin
         if (s0_rst_ff) begin
            pos_l_in      = '0;
            pos_r_in      = '0;
            prev_enc_l_in = '0;
            prev_enc_r_in = '0;
            prev_err_l_in = '0;
            prev_err_r_in = '0;
            count_in      = '0;
         end else begin
            pos_l_in      = np_l;
            pos_r_in      = np_r;
            prev_enc_l_in = s0_enc_l_ff;
            prev_enc_r_in = s0_enc_r_ff;
            prev_err_l_in = e_l;
            prev_err_r_in = e_r;
            count_in      = stable ? cnt_step : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         trk_ff.valid  <= 1'b0;
         pos_l_ff      <= '0;
         pos_r_ff      <= '0;
         prev_enc_l_ff <= '0;
         prev_enc_r_ff <= '0;
         prev_err_l_ff <= '0;
         prev_err_r_ff <= '0;
         count_ff      <= '0;
      end else if (adv) begin
         s0_valid_ff   <= req_bus.valid;
         trk_ff        <= trk_in;
         pos_l_ff      <= pos_l_in;
         pos_r_ff      <= pos_r_in;
         prev_enc_l_ff <= prev_enc_l_in;
         prev_enc_r_ff <= prev_enc_r_in;
         prev_err_l_ff <= prev_err_l_in;
         prev_err_r_ff <= prev_err_r_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_enc_l_ff    <= req_bus.enc_left_abs;
         s0_enc_r_ff    <= req_bus.enc_right_abs;
         s0_dir_l_ff    <= req_bus.dir_left;
         s0_dir_r_ff    <= req_bus.dir_right;
         s0_turn_ff     <= req_bus.turning;
         s0_rst_ff      <= req_bus.restart;
      end
   end

endmodule

>>> rtl/dwpd_gain.sv
// ----------------------------------------------------------------------------
// dwpd_gain
// Gain products (registered), then PD sum clamped to +/- pwm_max.
// ----------------------------------------------------------------------------
module dwpd_gain (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  dwpd_pkg::cfg_type   cfg,
   input  dwpd_pkg::trk_type   trk,
   output dwpd_pkg::pd_type    pd
);
   import dwpd_pkg::*;

   typedef struct packed {
      logic                      valid;
      logic                      turning;
      logic                      done;
      logic signed [PROP_W-1:0]  p_l;
      logic signed [PROP_W-1:0]  p_r;
      logic signed [DPROD_W-1:0] d_l;
      logic signed [DPROD_W-1:0] d_r;
      logic signed [SYNC_W-1:0]  sync;
   } mul_type;

   mul_type              mul_ff, mul_in;
   pd_type               pd_ff, pd_in;
   logic [GAIN_W-1:0]    kp, kd;
   logic signed [SUM_W-1:0] lim, sum_l, sum_r;

   function automatic logic signed [PD_W-1:0] clip(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] l
   );
      if (v > l) begin
         clip = PD_W'(l);
      end else if (v < -l) begin
         clip = PD_W'(-l);
      end else begin
         clip = PD_W'(v);
      end
   endfunction

   assign pd = pd_ff;

   always_comb begin
      kp = trk.turning ? cfg.kp_turn : cfg.kp_line;
      kd = trk.turning ? cfg.kd_turn : cfg.kd_line;

      mul_in.valid   = trk.valid;
      mul_in.turning = trk.turning;
      mul_in.done    = trk.done;
      mul_in.p_l     = PROP_W'($signed({1'b0, kp})) * PROP_W'(trk.err_l);
      mul_in.p_r     = PROP_W'($signed({1'b0, kp})) * PROP_W'(trk.err_r);
      mul_in.d_l     = DPROD_W'($signed({1'b0, kd})) * DPROD_W'(trk.derr_l);
      mul_in.d_r     = DPROD_W'($signed({1'b0, kd})) * DPROD_W'(trk.derr_r);
      mul_in.sync    = SYNC_W'($signed({1'b0, cfg.kp_sync})) * SYNC_W'(trk.sync_e);

      lim   = SUM_W'($signed({1'b0, cfg.pwm_max, FRAC_W'(0)}));
      sum_l = SUM_W'(mul_ff.p_l) + SUM_W'(mul_ff.d_l);
      sum_r = SUM_W'(mul_ff.p_r) + SUM_W'(mul_ff.d_r);

      pd_in.valid   = mul_ff.valid;
      pd_in.turning = mul_ff.turning;
      pd_in.done    = mul_ff.done;
      pd_in.pd_l    = clip(sum_l, lim);
      pd_in.pd_r    = clip(sum_r, lim);
      pd_in.sync    = mul_ff.sync;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
         pd_ff.valid  <= 1'b0;
      end else if (adv) begin
         mul_ff <= mul_in;
         pd_ff  <= pd_in;
      end
   end

endmodule

>>> rtl/dwpd_out.sv
// ----------------------------------------------------------------------------
// dwpd_out
// Sync correction, scale down toward zero, saturation and result register.
// ----------------------------------------------------------------------------
module dwpd_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  dwpd_pkg::pd_type  pd,
   dwpd_rsp_if.source        rsp_bus
);
   import dwpd_pkg::*;

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_LIMIT);

   logic                    valid_ff;
   logic signed [OUT_W-1:0] pwm_l_ff, pwm_r_ff, pwm_l_in, pwm_r_in;
   logic                    done_ff;
   logic                    sub_l, sub_r;
   logic signed [OSUM_W-1:0] v_l, v_r;

   function automatic logic signed [OUT_W-1:0] finish(input logic signed [OSUM_W-1:0] v);
      logic signed [OSUM_W-1:0] adj;
      logic signed [Q_W-1:0]    q;
      adj = v[OSUM_W-1] ? v + OSUM_W'((1 << FRAC_W) - 1) : v;
      q   = Q_W'(adj >>> FRAC_W);
      if (q > Q_MAX) begin
         finish = OUT_W'(Q_MAX);
      end else if (q < -Q_MAX) begin
         finish = OUT_W'(-Q_MAX);
      end else begin
         finish = OUT_W'(q);
      end
   endfunction

   always_comb begin
      sub_l    = pd.turning && pd.pd_l[PD_W-1];
      sub_r    = !(pd.turning && pd.pd_r[PD_W-1]);
      v_l      = sub_l ? OSUM_W'(pd.pd_l) - OSUM_W'(pd.sync)
                       : OSUM_W'(pd.pd_l) + OSUM_W'(pd.sync);
      v_r      = sub_r ? OSUM_W'(pd.pd_r) - OSUM_W'(pd.sync)
                       : OSUM_W'(pd.pd_r) + OSUM_W'(pd.sync);
      pwm_l_in = finish(v_l);
      pwm_r_in = finish(v_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= pd.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pwm_l_ff <= pwm_l_in;
         pwm_r_ff <= pwm_r_in;
         done_ff  <= pd.done;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.pwm_left  = pwm_l_ff;
   assign rsp_bus.pwm_right = pwm_r_ff;
   assign rsp_bus.done_res  = done_ff;

endmodule

>>> test/dual_wheel_pd_position_control_tb.sv
// ----------------------------------------------------------------------------
// dual_wheel_pd_position_control_tb
// Drives control ticks through the request channel and checks every drive
// result against a cycle-free predictor of the PD position loop. Phases use
// default, extreme, zero and random register settings: directed ticks,
// encoder sweeps into position saturation, long settle runs and random walks.
// ----------------------------------------------------------------------------
module dual_wheel_pd_position_control_tb;
   import dwpd_pkg::*;

   localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;
   localparam logic [ENC_W-1:0] ENC_TOP   = '1;
   localparam longint POS_HI = 134217727;
   localparam longint POS_LO = -134217728;
   localparam int SETTLE_TICKS = 20;
   localparam int SETTLE_TOL   = 80;

   typedef struct packed {
      logic [ENC_W-1:0] enc_l;
      logic [ENC_W-1:0] enc_r;
      logic [DIR_W-1:0] dir_l;
      logic [DIR_W-1:0] dir_r;
      logic             turning;
      logic             restart;
   } tick_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pwm_left;
      logic signed [OUT_W-1:0] pwm_right;
      logic                    done;
   } drive_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   wire  [DATA_W-1:0] csr_prdata;
   wire               csr_pready;

   dwpd_req_if req_bus();
   dwpd_rsp_if rsp_bus();

   dual_wheel_pd_position_control uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // predictor copy of registers and loop state
   cfg_type ctrl_cfg;
   longint  wheel_pos_l = 0, wheel_pos_r = 0;
   longint  last_enc_l = 0, last_enc_r = 0;
   longint  last_err_l = 0, last_err_r = 0;
   int      settle_count = 0;

   tick_type  tick_queue[$];
   drive_type pending_drive[$];
   tick_type  tick_on_bus;
   bit        calm = 1'b0;
   int        mismatch_count = 0;
   int        gen_enc_l = 0, gen_enc_r = 0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint track_wheel(longint p, longint delta, logic [DIR_W-1:0] d);
      if (d == DIR_FWD) begin
         p = p + delta;
      end else if (d == DIR_BACK) begin
         p = p - delta;
      end
      return clamp(p, POS_LO, POS_HI);
   endfunction

   function automatic logic signed [OUT_W-1:0] to_pwm(longint v);
      longint q;
      q = clamp(v / 4096, -longint'(OUT_LIMIT), longint'(OUT_LIMIT));
      return q[OUT_W-1:0];
   endfunction

   function automatic drive_type drive_for_tick(tick_type t);
      longint kp, kd, ks, lim, err_l, err_r, pd_l, pd_r, c, out_l, out_r;
      drive_type d;
      d = '0;
      if (t.restart) begin
         wheel_pos_l = 0; wheel_pos_r = 0;
         last_enc_l = 0; last_enc_r = 0;
         last_err_l = 0; last_err_r = 0;
         settle_count = 0;
         return d;
      end
      kp  = t.turning ? longint'(ctrl_cfg.kp_turn) : longint'(ctrl_cfg.kp_line);
      kd  = t.turning ? longint'(ctrl_cfg.kd_turn) : longint'(ctrl_cfg.kd_line);
      ks  = longint'(ctrl_cfg.kp_sync);
      lim = longint'(ctrl_cfg.pwm_max) * 4096;

      wheel_pos_l = track_wheel(wheel_pos_l, longint'(t.enc_l) - last_enc_l, t.dir_l);
      wheel_pos_r = track_wheel(wheel_pos_r, longint'(t.enc_r) - last_enc_r, t.dir_r);

      err_l = longint'(ctrl_cfg.goal_left) - wheel_pos_l;
      err_r = longint'(ctrl_cfg.goal_right) - wheel_pos_r;

      pd_l = clamp(kp * err_l + kd * (err_l - last_err_l), -lim, lim);
      pd_r = clamp(kp * err_r + kd * (err_r - last_err_r), -lim, lim);

      if (!t.turning) begin
         c = ks * (wheel_pos_r - wheel_pos_l);
         out_l = pd_l + c;
         out_r = pd_r - c;
      end else begin
         c = ks * (mag(wheel_pos_r) - mag(wheel_pos_l));
         out_l = pd_l < 0 ? pd_l - c : pd_l + c;
         out_r = pd_r < 0 ? pd_r + c : pd_r - c;
      end

      last_err_l = err_l;
      last_err_r = err_r;
      last_enc_l = longint'(t.enc_l);
      last_enc_r = longint'(t.enc_r);

      if (mag(err_l) <= SETTLE_TOL && mag(err_r) <= SETTLE_TOL) begin
         if (settle_count < 255) settle_count++;
      end else begin
         settle_count = 0;
      end

      d.pwm_left  = to_pwm(out_l);
      d.pwm_right = to_pwm(out_r);
      d.done      = settle_count >= SETTLE_TICKS;
      return d;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_drive.push_back(drive_for_tick(tick_on_bus));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tick_queue.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
               tick_on_bus = tick_queue.pop_front();
               req_bus.enc_left_abs  <= tick_on_bus.enc_l;
               req_bus.enc_right_abs <= tick_on_bus.enc_r;
               req_bus.dir_left      <= tick_on_bus.dir_l;
               req_bus.dir_right     <= tick_on_bus.dir_r;
               req_bus.turning       <= tick_on_bus.turning;
               req_bus.restart       <= tick_on_bus.restart;
               req_bus.valid         <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_drive.size() == 0) begin
               $error("result beat with no tick outstanding");
               mismatch_count++;
            end else begin
               want = pending_drive.pop_front();
               if (rsp_bus.pwm_left !== want.pwm_left) begin
                  $error("pwm_left expected %0d got %0d", want.pwm_left, rsp_bus.pwm_left);
                  mismatch_count++;
               end
               if (rsp_bus.pwm_right !== want.pwm_right) begin
                  $error("pwm_right expected %0d got %0d", want.pwm_right, rsp_bus.pwm_right);
                  mismatch_count++;
               end
               if (rsp_bus.done_res !== want.done) begin
                  $error("done_res expected %0d got %0d", want.done, rsp_bus.done_res);
                  mismatch_count++;
               end
            end
         end
         rsp_bus.ready <= calm || $urandom_range(99) >= 29;
      end
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(cfg_type c);
      csr_write(REG_GOAL_LEFT,   {{(DATA_W-POS_W){c.goal_left[POS_W-1]}}, c.goal_left});
      csr_write(REG_GOAL_RIGHT,  {{(DATA_W-POS_W){c.goal_right[POS_W-1]}}, c.goal_right});
      csr_write(REG_KP_LINE,     DATA_W'(c.kp_line));
      csr_write(REG_KD_LINE,     DATA_W'(c.kd_line));
      csr_write(REG_KP_TURN,     DATA_W'(c.kp_turn));
      csr_write(REG_KD_TURN,     DATA_W'(c.kd_turn));
      csr_write(REG_KP_SYNC,     DATA_W'(c.kp_sync));
      csr_write(REG_PWM_MAX,     DATA_W'(c.pwm_max));
      ctrl_cfg = c;
   endtask

   task automatic drain();
      while (tick_queue.size() != 0 || req_bus.valid || pending_drive.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_tick(logic [ENC_W-1:0] el, logic [ENC_W-1:0] er,
                            logic [DIR_W-1:0] dl, logic [DIR_W-1:0] dr,
                            logic turn, logic rst);
      tick_type t;
      t = '{enc_l: el, enc_r: er, dir_l: dl, dir_r: dr, turning: turn, restart: rst};
      tick_queue.push_back(t);
   endtask

   function automatic logic [DIR_W-1:0] pick_dir();
      int r;
      r = $urandom_range(99);
      if (r < 45) return DIR_FWD;
      if (r < 90) return DIR_BACK;
      if (r < 95) return DIR_STOP;
      return DIR_SPARE;
   endfunction

   function automatic logic [ENC_W-1:0] rand_enc();
      return ENC_W'($urandom_range(0, ENC_TOP));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic add_noise(int n);
      repeat (n)
         push_tick(rand_enc(), rand_enc(),
                   DIR_W'($urandom_range(0, 3)), DIR_W'($urandom_range(0, 3)),
                   rand_bit(), $urandom_range(0, 29) == 0);
   endtask

   // small encoder steps so the loop can actually converge and settle
   task automatic add_walk(int n, int step);
      repeat (n) begin
         gen_enc_l = int'(clamp(longint'(gen_enc_l) + longint'($urandom_range(0, 2*step))
                                - longint'(step), 0, longint'(ENC_TOP)));
         gen_enc_r = int'(clamp(longint'(gen_enc_r) + longint'($urandom_range(0, 2*step))
                                - longint'(step), 0, longint'(ENC_TOP)));
         push_tick(ENC_W'(gen_enc_l), ENC_W'(gen_enc_r), pick_dir(), pick_dir(),
                   rand_bit(), $urandom_range(0, 59) == 0);
      end
   endtask

   // full-scale encoder swings with direction chosen so position runs one way
   task automatic add_sweep(bit upward, int n);
      logic [ENC_W-1:0] e;
      logic             hi;
      push_tick('0, '0, DIR_STOP, DIR_STOP, 1'b0, 1'b1);
      for (int k = 0; k < n; k++) begin
         hi = (k % 2) == 0;
         e  = hi ? ENC_TOP : '0;
         push_tick(e, e,
                   (hi ^ !upward) ? DIR_FWD : DIR_BACK,
                   (hi ^ upward) ? DIR_FWD : DIR_BACK,
                   rand_bit(), 1'b0);
      end
   endtask

   function automatic logic [GAIN_W-1:0] rand_gain();
      return $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 16'hFFFF))
                                  : GAIN_W'($urandom_range(0, 1024));
   endfunction

   function automatic logic signed [POS_W-1:0] rand_goal();
      return $urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, 400) - 200);
   endfunction

   initial begin
      cfg_type c;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.enc_left_abs = '0;
      req_bus.enc_right_abs = '0;
      req_bus.dir_left = DIR_STOP;
      req_bus.dir_right = DIR_STOP;
      req_bus.turning = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      ctrl_cfg = '{goal_left: '0, goal_right: '0, kp_line: 16'd256, kd_line: '0,
                   kp_turn: 16'd256, kd_turn: '0, kp_sync: '0, pwm_max: 12'd1000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed ticks under reset defaults
      push_tick(ENC_TOP, ENC_TOP, DIR_SPARE, DIR_SPARE, 1'b1, 1'b1);
      push_tick('0, '0, DIR_STOP, DIR_STOP, 1'b0, 1'b0);
      push_tick(ENC_TOP, ENC_TOP, DIR_FWD, DIR_FWD, 1'b0, 1'b0);
      push_tick('0, '0, DIR_BACK, DIR_BACK, 1'b0, 1'b0);
      push_tick(ENC_TOP, '0, DIR_SPARE, DIR_SPARE, 1'b1, 1'b0);
      push_tick('0, ENC_TOP, DIR_FWD, DIR_BACK, 1'b1, 1'b0);
      push_tick(20'h12345, 20'hABCDE, DIR_BACK, DIR_FWD, 1'b0, 1'b0);
      push_tick(20'h55555, 20'hAAAAA, DIR_STOP, DIR_FWD, 1'b1, 1'b0);
      push_tick(20'hAAAAA, 20'h55555, DIR_FWD, DIR_STOP, 1'b0, 1'b0);
      push_tick(20'h00010, 20'h00020, DIR_FWD, DIR_FWD, 1'b0, 1'b1);
      push_tick(20'h00010, 20'h00020, DIR_FWD, DIR_FWD, 1'b0, 1'b0);
      push_tick(20'h00005, 20'h00030, DIR_BACK, DIR_FWD, 1'b1, 1'b0);
      push_tick(ENC_TOP, ENC_TOP, DIR_FWD, DIR_BACK, 1'b0, 1'b0);
      push_tick('0, '0, DIR_FWD, DIR_BACK, 1'b1, 1'b0);
      push_tick(20'h7FFFF, 20'h80000, DIR_BACK, DIR_BACK, 1'b0, 1'b0);
      push_tick('0, '0, DIR_STOP, DIR_STOP, 1'b0, 1'b1);
      drain();

      // extreme gains and goals, position saturation both ways
      c = '{goal_left: 28'sh7FFFFFF, goal_right: 28'sh8000000, kp_line: 16'hFFFF,
            kd_line: 16'hFFFF, kp_turn: 16'd1, kd_turn: 16'hFFFF, kp_sync: 16'hFFFF,
            pwm_max: 12'hFFF};
      set_config(c);
      add_noise(30);
      add_sweep(1'b1, 130);
      add_sweep(1'b0, 130);
      drain();

      // settle runs with no stalls on either side
      calm = 1'b1;
      c = '{goal_left: '0, goal_right: '0, kp_line: 16'd256, kd_line: 16'd128,
            kp_turn: 16'd300, kd_turn: 16'd50, kp_sync: 16'd16, pwm_max: 12'd1000};
      set_config(c);
      push_tick('0, '0, DIR_STOP, DIR_STOP, 1'b0, 1'b1);
      repeat (265)
         push_tick(rand_enc(), rand_enc(), DIR_STOP, DIR_STOP, rand_bit(), 1'b0);
      gen_enc_l = 0;
      gen_enc_r = 0;
      push_tick('0, '0, DIR_STOP, DIR_STOP, 1'b0, 1'b1);
      add_walk(60, 3);
      drain();
      calm = 1'b0;

      // random register settings
      repeat (4) begin
         c = '{goal_left: rand_goal(), goal_right: rand_goal(), kp_line: rand_gain(),
               kd_line: rand_gain(), kp_turn: rand_gain(), kd_turn: rand_gain(),
               kp_sync: rand_gain(), pwm_max: PWM_W'($urandom_range(0, 12'hFFF))};
         set_config(c);
         add_walk(18, int'($urandom_range(1, 8)));
         add_walk(10, int'($urandom_range(100, 60000)));
         add_noise(10);
         drain();
      end

      // all gains and clamp at zero, goals at the opposite extremes
      c = '{goal_left: 28'sh8000000, goal_right: 28'sh7FFFFFF, kp_line: '0,
            kd_line: '0, kp_turn: '0, kd_turn: '0, kp_sync: '0, pwm_max: '0};
      set_config(c);
      add_noise(20);
      drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
rtl/dwpd_pkg.sv
rtl/dwpd_if.sv
rtl/dwpd_csr.sv
rtl/dwpd_track.sv
rtl/dwpd_gain.sv
rtl/dwpd_out.sv
rtl/dual_wheel_pd_position_control.sv
test/dual_wheel_pd_position_control_tb.sv
